### rtl/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared constants and types of the Lagrange segment interpolator: field
// widths, register indexes, reset values and saturation limits.
// ----------------------------------------------------------------------------
`default_nettype none

package lsi_pkg;

	localparam int NODE_REGS     = 6;
	localparam int MAX_NODES_DEF = 6;

	localparam int TIME_W     = 24;
	localparam int SAMPLE_W   = 32;
	localparam int NODE_W     = 16;
	localparam int ORDER_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CNT_W      = 4;

	localparam int TAU_W = 29;
	localparam int W_W   = 32;
	localparam int NQ_W  = 18;

	localparam int DIV_STEPS   = 4;
	localparam int TAU_QW      = 29;
	localparam int W_QW        = 33;
	localparam int TAU_DIV_LAT = (TAU_QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int W_DIV_LAT   = (W_QW + DIV_STEPS - 1) / DIV_STEPS;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE0   = 3'd2;

	localparam logic [ORDER_W-1:0] ORDER_RST   = 3'd1;
	localparam logic [TIME_W-1:0]  SEG_LEN_RST = 24'd65536;
	localparam logic signed [NODE_W-1:0] NODE_RST [NODE_REGS] =
		'{-16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0};

	localparam logic signed [W_W-1:0] W_ONE = 32'sh0100_0000;
	localparam logic signed [W_W-1:0] W_MAX = 32'sh7fff_ffff;
	localparam logic signed [W_W-1:0] W_MIN = 32'sh8000_0000;

	localparam logic signed [TAU_W-1:0] TAU_MAX = 29'sh0fff_ffff;
	localparam logic signed [TAU_W-1:0] TAU_MIN = 29'sh1000_0000;

	typedef struct packed {
		logic signed [TAU_W-1:0]        tau;
		logic [NODE_REGS*SAMPLE_W-1:0]  smp;
	} glb_t;

	typedef struct packed {
		logic signed [W_W-1:0] w_old;
		logic                  neg;
		logic                  ovf;
		logic                  act;
	} wsb_t;

endpackage

`default_nettype wire

### rtl/lsi_item_if.sv
// ----------------------------------------------------------------------------
// lsi_item_if
// Input channel: time offset in the segment and the node samples of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsi_item_if;
	logic               valid;
	logic               ready;
	logic [23:0]        time_in_segment;
	logic signed [31:0] sample_0;
	logic signed [31:0] sample_1;
	logic signed [31:0] sample_2;
	logic signed [31:0] sample_3;
	logic signed [31:0] sample_4;
	logic signed [31:0] sample_5;

	modport source (
		output valid, time_in_segment,
		output sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
		input  ready
	);
	modport sink (
		input  valid, time_in_segment,
		input  sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
		output ready
	);
endinterface

`default_nettype wire

### rtl/lsi_result_if.sv
// ----------------------------------------------------------------------------
// lsi_result_if
// Output channel: interpolated value and the equal-node error flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsi_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] interpolated;
	logic               node_error;

	modport source (output valid, interpolated, node_error, input ready);
	modport sink (input valid, interpolated, node_error, output ready);
endinterface

`default_nettype wire

### rtl/lagrange_segment_interpolator_unit.sv
// ----------------------------------------------------------------------------
// lagrange_segment_interpolator_unit
// Evaluates one Lagrange polynomial segment at a time offset per beat.
//
// sample_ch carries the time offset (Q8.16) and the node samples (Q16.16);
// result_ch returns the saturated interpolated value and the node error flag.
// The cfg port writes order, segment length and node positions; write it only
// while no beat is in flight.
// One beat is taken every cycle while the receiver does not stall. The stages
// are the same whatever the order: input stage, 8-stage divider for tau, tau
// saturation, then per extra lane one round of multiply, magnitude, 9-stage
// divider and saturation, then product, rounding, sum and output stages, lanes
// being the smaller of MAX_NODES and six.
// The divider chains set the latency; one beat per cycle unless stalled.
// Reset clears the valid bits and loads the default configuration.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and sample_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lagrange_segment_interpolator_unit #(
	parameter int MAX_NODES = lsi_pkg::MAX_NODES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lsi_item_if.sink                         sample_ch,
	lsi_result_if.source                     result_ch,
	input  logic                             cfg_write,
	input  logic [lsi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsi_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lsi_pkg::*;

	localparam int LANES = (MAX_NODES < NODE_REGS) ? MAX_NODES : NODE_REGS;
	localparam int NR    = LANES - 1;
	localparam int RL    = 3 + W_DIV_LAT;
	localparam int LAT   = 6 + TAU_DIV_LAT + NR * RL;
	localparam int SUM_W = 40 + $clog2(LANES);

	// configuration
	logic [ORDER_W-1:0]       order_q;
	logic [TIME_W-1:0]        seg_len_q;
	logic signed [NODE_W-1:0] node_q [NODE_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q   <= ORDER_RST;
			seg_len_q <= SEG_LEN_RST;
			for (int k = 0; k < NODE_REGS; k++) begin
				node_q[k] <= NODE_RST[k];
			end
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ORDER:   order_q   <= cfg_data[ORDER_W-1:0];
				REG_SEG_LEN: seg_len_q <= cfg_data[TIME_W-1:0];
				default:     node_q[3'(cfg_index - REG_NODE0)] <= cfg_data[NODE_W-1:0];
			endcase
		end
	end

	logic [TIME_W-1:0]      dt;
	logic [CNT_W-1:0]       cnt;
	logic                   node_err;
	logic signed [NQ_W-1:0] nq [LANES];

	assign dt = (seg_len_q == '0) ? TIME_W'(1) : seg_len_q;

	always_comb begin
		cnt = CNT_W'(order_q) + CNT_W'(1);
		if (cnt > CNT_W'(LANES)) begin
			cnt = CNT_W'(LANES);
		end
	end

	always_comb begin
		node_err = 1'b0;
		for (int a = 0; a < LANES; a++) begin
			for (int b = a + 1; b < LANES; b++) begin
				if ((CNT_W'(b) < cnt) && (node_q[a] == node_q[b])) begin
					node_err = 1'b1;
				end
			end
		end
	end

	for (genvar k = 0; k < LANES; k++) begin : g_nq
		assign nq[k] = {node_q[k], 2'b00};
	end

	// handshake: one enable for the whole pipeline
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv             = !vld_q[LAT-1] || result_ch.ready;
	assign sample_ch.ready = adv;
	assign result_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], sample_ch.valid};
		end
	end

	// s1: numerator (2t - dt) * 2^16 as sign and magnitude
	logic signed [25:0]            tdiff;
	logic [24:0]                   tabs;
	logic [40:0]                   nabs_s1;
	logic                          neg_s1;
	logic                          ovf_s1;
	logic [NODE_REGS*SAMPLE_W-1:0] smp_s1;

	assign tdiff = $signed({1'b0, sample_ch.time_in_segment, 1'b0}) - $signed({2'b00, dt});
	assign tabs  = tdiff[25] ? 25'(-tdiff) : tdiff[24:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			nabs_s1 <= {tabs, 16'b0};
			neg_s1  <= tdiff[25];
			ovf_s1  <= ({12'b0, tabs[24:13]} >= dt);
			smp_s1  <= {sample_ch.sample_5, sample_ch.sample_4, sample_ch.sample_3,
				sample_ch.sample_2, sample_ch.sample_1, sample_ch.sample_0};
		end
	end

	// tau divider
	logic [TAU_QW-1:0]               tq;
	logic [NODE_REGS*SAMPLE_W+1:0]   tsb;

	lsi_div #(
		.QW  (TAU_QW),
		.RW  (TIME_W),
		.SBW (NODE_REGS*SAMPLE_W + 2)
	) u_tau_div (
		.clk      (clk),
		.en       (adv),
		.rem_init ({12'b0, nabs_s1[40:29]}),
		.num      (nabs_s1[28:0]),
		.den      (dt),
		.sb_in    ({smp_s1, neg_s1, ovf_s1}),
		.quo      (tq),
		.sb_out   (tsb)
	);

	// s2: sign and saturate tau
	logic signed [TAU_W-1:0] tau_c;
	glb_t                    g_s2;

	always_comb begin
		if (tsb[0]) begin
			tau_c = tsb[1] ? TAU_MIN : TAU_MAX;
		end else if (!tsb[1]) begin
			tau_c = tq[TAU_QW-1] ? TAU_MAX : $signed(tq);
		end else if (tq > 29'h1000_0000) begin
			tau_c = TAU_MIN;
		end else begin
			tau_c = $signed(TAU_W'(~tq + 1'b1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s2.tau <= tau_c;
			g_s2.smp <= tsb[NODE_REGS*SAMPLE_W+1:2];
		end
	end

	// weight rounds: round r applies factor j to every lane, j ascending, j != lane
	glb_t                  g_in [NR+1];
	logic signed [W_W-1:0] w_in [NR+1][LANES];

	assign g_in[0] = g_s2;
	for (genvar i = 0; i < LANES; i++) begin : g_w0
		assign w_in[0][i] = W_ONE;
	end

	for (genvar r = 0; r < NR; r++) begin : g_round
		glb_t g_mul;
		glb_t g_prep;
		glb_t g_post;
		glb_t g_dly [W_DIV_LAT];

		always_ff @(posedge clk) begin
			if (adv) begin
				g_mul    <= g_in[r];
				g_prep   <= g_mul;
				g_dly[0] <= g_prep;
				for (int k = 1; k < W_DIV_LAT; k++) begin
					g_dly[k] <= g_dly[k-1];
				end
				g_post <= g_dly[W_DIV_LAT-1];
			end
		end

		assign g_in[r+1] = g_post;

		for (genvar i = 0; i < LANES; i++) begin : g_lane
			localparam int J = (r < i) ? r : r + 1;

			logic                   act;
			logic signed [29:0]     diff;
			logic signed [61:0]     prod_m;
			logic signed [W_W-1:0]  wold_m;
			logic [61:0]            pabs_c;
			logic signed [NQ_W:0]   den_c;
			logic [NQ_W-1:0]        dabs;
			logic [61:0]            pabs_p;
			wsb_t                   sb_p;
			wsb_t                   sb_d;
			logic [W_QW-1:0]        wq;
			logic signed [W_W-1:0]  wnew;
			logic signed [W_W-1:0]  w_post;

			assign act  = (CNT_W'(i) < cnt) && (CNT_W'(J) < cnt);
			assign diff = 30'(g_in[r].tau) - 30'(nq[J]);

			always_ff @(posedge clk) begin
				if (adv) begin
					prod_m <= w_in[r][i] * diff;
					wold_m <= w_in[r][i];
				end
			end

			assign pabs_c = prod_m[61] ? 62'(-prod_m) : $unsigned(prod_m);
			assign den_c  = (NQ_W+1)'(nq[i]) - (NQ_W+1)'(nq[J]);
			assign dabs   = den_c[NQ_W] ? NQ_W'(-den_c) : den_c[NQ_W-1:0];

			always_ff @(posedge clk) begin
				if (adv) begin
					pabs_p     <= pabs_c;
					sb_p.w_old <= wold_m;
					sb_p.neg   <= prod_m[61] ^ den_c[NQ_W];
					sb_p.ovf   <= (pabs_c[61:33] >= 29'(dabs));
					sb_p.act   <= act;
				end
			end

			lsi_div #(
				.QW  (W_QW),
				.RW  (NQ_W),
				.SBW ($bits(wsb_t))
			) u_w_div (
				.clk      (clk),
				.en       (adv),
				.rem_init (pabs_p[50:33]),
				.num      (pabs_p[32:0]),
				.den      (dabs),
				.sb_in    (sb_p),
				.quo      (wq),
				.sb_out   (sb_d)
			);

			always_comb begin
				if (!sb_d.act) begin
					wnew = sb_d.w_old;
				end else if (sb_d.ovf) begin
					wnew = sb_d.neg ? W_MIN : W_MAX;
				end else if (!sb_d.neg) begin
					wnew = (wq[32] | wq[31]) ? W_MAX : $signed(wq[31:0]);
				end else if (wq > 33'h0_8000_0000) begin
					wnew = W_MIN;
				end else begin
					wnew = $signed(W_W'(~wq + 1'b1));
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					w_post <= wnew;
				end
			end

			assign w_in[r+1][i] = w_post;
		end
	end

	// s3..s6: weighted terms, rounding, sum, saturation
	logic signed [63:0]       term_s3 [LANES];
	logic signed [39:0]       rnd_s4  [LANES];
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  sum_s5;
	logic signed [W_W-1:0]    interp_s6;
	logic                     nerr_s6;
	logic                     pos_ovf;
	logic                     neg_ovf;

	for (genvar i = 0; i < LANES; i++) begin : g_term
		logic signed [63:0] rsum;

		assign rsum = term_s3[i] + 64'sd8388608;

		always_ff @(posedge clk) begin
			if (adv) begin
				term_s3[i] <= w_in[NR][i] * $signed(g_in[NR].smp[i*SAMPLE_W +: SAMPLE_W]);
				rnd_s4[i]  <= (CNT_W'(i) < cnt) ? 40'(rsum >>> 24) : '0;
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < LANES; i++) begin
			sum_c = sum_c + SUM_W'(rnd_s4[i]);
		end
	end

	assign pos_ovf = !sum_s5[SUM_W-1] && (|sum_s5[SUM_W-2:31]);
	assign neg_ovf = sum_s5[SUM_W-1] && !(&sum_s5[SUM_W-2:31]);

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5  <= sum_c;
			nerr_s6 <= node_err;
			if (node_err) begin
				interp_s6 <= '0;
			end else if (pos_ovf) begin
				interp_s6 <= W_MAX;
			end else if (neg_ovf) begin
				interp_s6 <= W_MIN;
			end else begin
				interp_s6 <= sum_s5[W_W-1:0];
			end
		end
	end

	assign result_ch.interpolated = interp_s6;
	assign result_ch.node_error   = nerr_s6;

	// checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.node_error |-> result_ch.interpolated == '0)
		else $error("node error beat with nonzero value");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-1] && !result_ch.ready |=> $stable(vld_q))
		else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

### rtl/lsi_div.sv
// ----------------------------------------------------------------------------
// lsi_div
// Pipelined restoring divider, a few quotient bits per stage, with a side
// band that travels along with the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_div #(
	parameter int QW  = 33,
	parameter int RW  = 18,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           en,
	input  logic [RW-1:0]  rem_init,
	input  logic [QW-1:0]  num,
	input  logic [RW-1:0]  den,
	input  logic [SBW-1:0] sb_in,
	output logic [QW-1:0]  quo,
	output logic [SBW-1:0] sb_out
);
	import lsi_pkg::*;

	localparam int NS = (QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int AW = RW + QW;

	logic [AW-1:0]  acc_s [NS];
	logic [SBW-1:0] sb_s  [NS];

	// one restoring step: remainder in the top, quotient shifts into the bottom
	function automatic logic [AW-1:0] div_step(input logic [AW-1:0] a, input logic [RW-1:0] d);
		logic [RW:0] t;
		logic [RW:0] diff;
		t    = a[AW-1:QW-1];
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			return {diff[RW-1:0], a[QW-2:0], 1'b1};
		end
		return {t[RW-1:0], a[QW-2:0], 1'b0};
	endfunction

	for (genvar s = 0; s < NS; s++) begin : g_stage
		localparam int FIRST = s * DIV_STEPS;
		localparam int NSTEP = (QW - FIRST < DIV_STEPS) ? (QW - FIRST) : DIV_STEPS;

		logic [AW-1:0]  src;
		logic [AW-1:0]  nxt;
		logic [SBW-1:0] sb_src;

		if (s == 0) begin : g_first
			assign src    = {rem_init, num};
			assign sb_src = sb_in;
		end else begin : g_next
			assign src    = acc_s[s-1];
			assign sb_src = sb_s[s-1];
		end

		always_comb begin
			nxt = src;
			for (int k = 0; k < NSTEP; k++) begin
				nxt = div_step(nxt, den);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[s] <= nxt;
				sb_s[s]  <= sb_src;
			end
		end
	end

	assign quo    = acc_s[NS-1][QW-1:0];
	assign sb_out = sb_s[NS-1];

endmodule

`default_nettype wire
